// ----- rtl/sscel_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the series function unit.
package sscel_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int GUARD_BITS = 16;
	localparam int IF_BITS    = FRAC_BITS + GUARD_BITS;
	localparam int DEN_W      = 34;

	localparam logic [1:0] MODE_SIN = 2'd0;
	localparam logic [1:0] MODE_COS = 2'd1;
	localparam logic [1:0] MODE_EXP = 2'd2;
	localparam logic [1:0] MODE_LN  = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_DOMAIN = 2'd1;
	localparam logic [1:0] STAT_SAT    = 2'd2;

	localparam logic signed [63:0] ONE = 64'sd1 <<< IF_BITS;
	localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PIH60 = 64'h1921_FB54_442D_1847;
	localparam logic signed [63:0] HALF_PI =
		64'((PIH60 + (64'd1 << (59 - IF_BITS))) >> (60 - IF_BITS));

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] arg;
	} job_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic [1:0]         status;
		logic [10:0]        terms_used;
	} res_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_KDIV, OP_KSET, OP_KMUL, OP_RSET, OP_DDIV, OP_DSET,
		OP_SQMUL, OP_SQSET, OP_TMUL, OP_LNMUL, OP_TDIVQ, OP_TDIVR, OP_TACC,
		OP_OVF, OP_FIN
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       ln_nonpos;
		logic       mul_done;
		logic       div_done;
		logic       qmul_ovf;
		logic       t_zero;
		logic       n_lim;
		logic       ovf;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/sscel_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sign-magnitude 64x64 multiplier built from four 32x32 partial products.
module sscel_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               busy,
	output logic               done,
	output logic               neg,
	output logic [127:0]       prod
);
	logic [63:0]  am_q, bm_q;
	logic [1:0]   idx_q;
	logic         busy_q, done_q, neg_q;
	logic [127:0] acc_q;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	always_comb begin
		ah = idx_q[1] ? am_q[63:32] : am_q[31:0];
		bh = idx_q[0] ? bm_q[63:32] : bm_q[31:0];
		pp = {32'd0, ah} * {32'd0, bh};
		pp_sh = {64'd0, pp} << {idx_q[1] & idx_q[0], idx_q[1] ^ idx_q[0], 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (busy_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
			bm_q  <= b[63] ? (64'd0 - $unsigned(b)) : $unsigned(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign neg  = neg_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ----- rtl/sscel_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module sscel_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                num,
	input  logic [sscel_pkg::DEN_W-1:0] den,
	output logic                       busy,
	output logic                       done,
	output logic [63:0]                quo,
	output logic [sscel_pkg::DEN_W-1:0] rem
);
	import sscel_pkg::*;

	logic [63:0]      q_q;
	logic [DEN_W-1:0] r_q, d_q;
	logic [5:0]       cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   rsh, rsub;
	logic             ge;

	always_comb begin
		rsh  = {r_q, q_q[63]};
		ge   = rsh >= {1'b0, d_q};
		rsub = rsh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			q_q <= {q_q[62:0], ge};
			r_q <= ge ? rsub[DEN_W-1:0] : rsh[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule
`default_nettype wire

// ----- rtl/sscel_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath: operand registers, shared multiplier and divider, result register.
module sscel_dp #(
	parameter int MAX_TERMS = 100,
	parameter int LN_TERMS  = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sscel_pkg::cmd_t cmd,
	output sscel_pkg::stat_t st,
	input  sscel_pkg::job_t job,
	output logic            res_valid,
	input  logic            res_stall,
	output sscel_pkg::res_t res
);
	import sscel_pkg::*;

	localparam int TOP_TERMS = (MAX_TERMS > LN_TERMS) ? MAX_TERMS : LN_TERMS;
	localparam int NW = $clog2(TOP_TERMS + 1);

	logic [1:0]         mode_q, quad_q;
	logic signed [31:0] v_q;
	logic signed [63:0] x_q, k_q, base_q, fac_q, t_q, sum_q;
	logic [NW-1:0]      n_q;
	logic               ovf_q, tsgn_q, numneg_q, dneg_q;
	res_t               res_q;
	logic               res_valid_q;

	logic               mul_start, mul_busy, mul_done, mneg;
	logic [127:0]       mprod;
	logic signed [63:0] mul_a, mul_b;
	logic               div_start, div_busy, div_done;
	logic [63:0]        div_num, quo;
	logic [DEN_W-1:0]   div_den, rem;

	logic [127:0]       full;
	logic [63:0]        qmag;
	logic               qovf;
	logic signed [63:0] qval;
	logic [DEN_W-1:0]   nz, nsq, two_n, tden, lnm, lnden;
	logic signed [63:0] knum, a64, kh, rval, kinc, sq, tnew, newsum, dval, fval;
	logic [63:0]        knmag, amag, dq, fmag, rnd;
	logic               trig, is_exp, is_ln, ln_nonpos, sat_pos, sat_neg, out_free;
	res_t               fin;

	always_comb begin
		trig      = ~mode_q[1];
		is_exp    = mode_q == MODE_EXP;
		is_ln     = mode_q == MODE_LN;
		ln_nonpos = v_q[31] || (v_q == 32'sd0);
		out_free  = !res_valid_q || !res_stall;

		full = mprod + (128'd1 << (IF_BITS - 1));
		qmag = full[IF_BITS +: 64];
		qovf = (full[127:64+IF_BITS] != '0) || ($signed(qmag) > LIM) || qmag[63];
		qval = qovf ? 64'sd0 : (mneg ? -$signed(qmag) : $signed(qmag));

		nz    = DEN_W'(n_q);
		nsq   = nz * nz;
		two_n = nz << 1;
		lnm   = two_n - DEN_W'(1);
		if (trig)
			tden = (quad_q[0] == 1'b0) ? ((nsq << 2) + two_n) : ((nsq << 2) - two_n);
		else if (is_exp)
			tden = nz;
		else
			tden = two_n + DEN_W'(1);

		knum  = (x_q <<< 1) + HALF_PI;
		knmag = knum[63] ? (64'd0 - $unsigned(knum)) : $unsigned(knum);
		a64   = 64'(v_q) - (64'sd1 <<< FRAC_BITS);
		amag  = a64[63] ? (64'd0 - $unsigned(a64)) : $unsigned(a64);
		lnden = DEN_W'(v_q) + (DEN_W'(1) << FRAC_BITS);

		kinc = $signed(quo + 64'(rem != '0));
		kh   = mneg ? -$signed(mprod[63:0]) : $signed(mprod[63:0]);
		rval = x_q - kh;
		dq   = quo + 64'({rem, 1'b0} >= {1'b0, lnden});
		dval = dneg_q ? -$signed(dq) : $signed(dq);

		sq     = tsgn_q ? -$signed(quo) : $signed(quo);
		tnew   = trig ? -sq : sq;
		newsum = sum_q + tnew;

		mul_start = 1'b0;
		mul_a     = t_q;
		mul_b     = fac_q;
		div_start = 1'b0;
		div_num   = (qovf ? 64'd0 : qmag) + 64'(tden >> 1);
		div_den   = tden;
		unique case (cmd.op)
			OP_KMUL: begin
				mul_start = 1'b1;
				mul_a     = k_q;
				mul_b     = HALF_PI;
			end
			OP_SQMUL: begin
				mul_start = 1'b1;
				mul_a     = base_q;
				mul_b     = base_q;
			end
			OP_TMUL: mul_start = 1'b1;
			OP_LNMUL: begin
				mul_start = 1'b1;
				mul_a     = qval;
				mul_b     = $signed(64'(lnm));
			end
			OP_KDIV: begin
				div_start = 1'b1;
				div_num   = knmag;
				div_den   = DEN_W'(HALF_PI << 1);
			end
			OP_DDIV: begin
				div_start = 1'b1;
				div_num   = amag << IF_BITS;
				div_den   = lnden;
			end
			OP_TDIVQ: div_start = 1'b1;
			OP_TDIVR: begin
				div_start = 1'b1;
				div_num   = mprod[63:0] + 64'(tden >> 1);
			end
			default: ;
		endcase

		if (trig)
			fval = quad_q[1] ? -sum_q : sum_q;
		else if (is_exp)
			fval = sum_q;
		else
			fval = sum_q <<< 1;
		fmag    = fval[63] ? (64'd0 - $unsigned(fval)) : $unsigned(fval);
		rnd     = (fmag + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
		sat_pos = !fval[63] && (rnd > 64'h7FFF_FFFF);
		sat_neg = fval[63] && (rnd > 64'h8000_0000);

		fin.terms_used = 11'(n_q);
		fin.status     = STAT_OK;
		if (is_ln && ln_nonpos) begin
			fin.result     = 32'sd0;
			fin.status     = STAT_DOMAIN;
			fin.terms_used = 11'd0;
		end else if (ovf_q) begin
			fin.result = (v_q > 32'sd0) ? 32'sh7FFF_FFFF : 32'sd0;
			fin.status = STAT_SAT;
		end else if (sat_pos) begin
			fin.result = 32'sh7FFF_FFFF;
			fin.status = STAT_SAT;
		end else if (sat_neg) begin
			fin.result = 32'sh8000_0000;
			fin.status = STAT_SAT;
		end else begin
			fin.result = fval[63] ? $signed(32'd0 - rnd[31:0]) : $signed(rnd[31:0]);
		end
	end

	sscel_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .neg(mneg), .prod(mprod)
	);

	sscel_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(quo), .rem(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_LOAD: ovf_q <= 1'b0;
				OP_OVF: ovf_q <= 1'b1;
				OP_TACC: begin
					if (is_exp && (newsum > LIM || newsum < -LIM))
						ovf_q <= 1'b1;
				end
				OP_FIN: res_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q <= job.mode;
				v_q    <= job.arg;
				x_q    <= 64'(job.arg) <<< GUARD_BITS;
				fac_q  <= 64'(job.arg) <<< GUARD_BITS;
				t_q    <= ONE;
				sum_q  <= ONE;
				n_q    <= NW'(1);
			end
			OP_KDIV: numneg_q <= knum[63];
			OP_KSET: begin
				k_q    <= numneg_q ? -kinc : $signed(quo);
				quad_q <= (numneg_q ? 2'(-kinc) : quo[1:0]) + mode_q;
			end
			OP_RSET: begin
				base_q <= rval;
				t_q    <= (quad_q[0] == 1'b0) ? rval : ONE;
				sum_q  <= (quad_q[0] == 1'b0) ? rval : ONE;
			end
			OP_DDIV: dneg_q <= a64[63];
			OP_DSET: begin
				base_q <= dval;
				t_q    <= dval;
				sum_q  <= dval;
			end
			OP_SQSET: fac_q <= qval;
			OP_TDIVQ, OP_TDIVR: tsgn_q <= mneg;
			OP_TACC: begin
				t_q   <= tnew;
				sum_q <= newsum;
				if (!(is_exp && (newsum > LIM || newsum < -LIM)))
					n_q <= n_q + NW'(1);
			end
			OP_FIN: res_q <= fin;
			default: ;
		endcase
	end

	always_comb begin
		st.mode      = mode_q;
		st.ln_nonpos = ln_nonpos;
		st.mul_done  = mul_done;
		st.div_done  = div_done;
		st.qmul_ovf  = qovf;
		st.t_zero    = t_q == 64'sd0;
		st.n_lim     = n_q >= (is_ln ? NW'(LN_TERMS) : NW'(MAX_TERMS));
		st.ovf       = ovf_q;
		st.out_free  = out_free;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FIN |-> out_free) else $error("result written over a waiting one");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy) else $error("multiplier restarted while busy");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_ovf_exp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> mode_q == MODE_EXP) else $error("overflow outside exponential");

endmodule
`default_nettype wire

// ----- rtl/sscel_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Controller that sequences the series evaluation through the datapath.
module sscel_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_stall,
	input  sscel_pkg::stat_t st,
	output sscel_pkg::cmd_t  cmd
);
	import sscel_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_KDIV, S_KDIV_W, S_KSET, S_KMUL, S_KMUL_W, S_RSET,
		S_DDIV, S_DDIV_W, S_DSET, S_SQMUL, S_SQMUL_W, S_SQSET, S_LOOP,
		S_TMUL, S_TMUL_W, S_LNMUL, S_LNMUL_W, S_TDIVQ, S_TDIVR, S_TDIV_W,
		S_TACC, S_OVF, S_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:  cmd.op = job_valid ? OP_LOAD : OP_NONE;
			S_KDIV:  cmd.op = OP_KDIV;
			S_KSET:  cmd.op = OP_KSET;
			S_KMUL:  cmd.op = OP_KMUL;
			S_RSET:  cmd.op = OP_RSET;
			S_DDIV:  cmd.op = OP_DDIV;
			S_DSET:  cmd.op = OP_DSET;
			S_SQMUL: cmd.op = OP_SQMUL;
			S_SQSET: cmd.op = OP_SQSET;
			S_TMUL:  cmd.op = OP_TMUL;
			S_LNMUL: cmd.op = OP_LNMUL;
			S_TDIVQ: cmd.op = OP_TDIVQ;
			S_TDIVR: cmd.op = OP_TDIVR;
			S_TACC:  cmd.op = OP_TACC;
			S_OVF:   cmd.op = OP_OVF;
			S_FIN:   cmd.op = st.out_free ? OP_FIN : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign job_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (job_valid) state_q <= S_DISP;
				S_DISP: begin
					if (st.mode == MODE_SIN || st.mode == MODE_COS)
						state_q <= S_KDIV;
					else if (st.mode == MODE_EXP)
						state_q <= S_LOOP;
					else if (st.ln_nonpos)
						state_q <= S_FIN;
					else
						state_q <= S_DDIV;
				end
				S_KDIV:   state_q <= S_KDIV_W;
				S_KDIV_W: if (st.div_done) state_q <= S_KSET;
				S_KSET:   state_q <= S_KMUL;
				S_KMUL:   state_q <= S_KMUL_W;
				S_KMUL_W: if (st.mul_done) state_q <= S_RSET;
				S_RSET:   state_q <= S_SQMUL;
				S_DDIV:   state_q <= S_DDIV_W;
				S_DDIV_W: if (st.div_done) state_q <= S_DSET;
				S_DSET:   state_q <= S_SQMUL;
				S_SQMUL:  state_q <= S_SQMUL_W;
				S_SQMUL_W: if (st.mul_done) state_q <= S_SQSET;
				S_SQSET:  state_q <= S_LOOP;
				S_LOOP: begin
					if (st.ovf || st.n_lim || st.t_zero)
						state_q <= S_FIN;
					else
						state_q <= S_TMUL;
				end
				S_TMUL: state_q <= S_TMUL_W;
				S_TMUL_W: begin
					if (st.mul_done) begin
						if (st.mode == MODE_EXP && st.qmul_ovf)
							state_q <= S_OVF;
						else if (st.mode == MODE_LN)
							state_q <= S_LNMUL;
						else
							state_q <= S_TDIVQ;
					end
				end
				S_LNMUL:   state_q <= S_LNMUL_W;
				S_LNMUL_W: if (st.mul_done) state_q <= S_TDIVR;
				S_TDIVQ:   state_q <= S_TDIV_W;
				S_TDIVR:   state_q <= S_TDIV_W;
				S_TDIV_W:  if (st.div_done) state_q <= S_TACC;
				S_TACC:    state_q <= S_LOOP;
				S_OVF:     state_q <= S_FIN;
				S_FIN:     if (st.out_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/series_sin_cos_exp_ln_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each series term passes through the shared multiplier and divider; ln adds a second multiply.
// Sin and cos run a reduction setup ahead of their series terms.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset clears the controller and the result valid flag; no clearing pass is needed.
module series_sin_cos_exp_ln_unit #(
	parameter int MAX_TERMS = 100,
	parameter int LN_TERMS  = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_stall,
	input  sscel_pkg::job_t job,
	output logic            res_valid,
	input  logic            res_stall,
	output sscel_pkg::res_t res
);
	import sscel_pkg::*;

	// The controller walks each function through its setup and then the
	// term loop; the datapath does the arithmetic on one shared multiplier
	// and one shared divider.
	cmd_t  cmd;
	stat_t st;

	sscel_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.st(st),
		.cmd(cmd)
	);

	// The result register sits in the datapath, so a finished result may
	// wait for its transfer while the next item is already being worked on.
	sscel_dp #(
		.MAX_TERMS(MAX_TERMS),
		.LN_TERMS(LN_TERMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.job(job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench of the series sine, cosine, exponential and logarithm unit.
module tb_top;
	import sscel_pkg::*;

	// Series lengths of the instance; they match the defaults of the block.
	localparam int SER_TERMS = 100;
	localparam int LOG_TERMS = 1024;
	// Runs of about a hundred items stay well inside the limit, though a few
	// logarithms near the ends of the range run much longer than other items.
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int RAND_ITEMS = 100;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [127:0] MAG_LIM = 128'h3FFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic job_valid;
	logic job_stall;
	job_t job;
	logic res_valid;
	logic res_stall;
	res_t res;

	series_sin_cos_exp_ln_unit #(
		.MAX_TERMS(SER_TERMS),
		.LN_TERMS (LOG_TERMS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.job      (job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// Results still owed by the block, oldest first.
	res_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	// Set by the sender to make the receiver hold off for a long stretch.
	bit hold_req = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung block ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Fixed-point arithmetic of the predictor. The accumulator has 32
	// fraction bits; every rounding is to nearest with ties away from zero.
	// ---------------------------------------------------------------------
	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [63:0] signed_of(input logic [63:0] m, input bit neg);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// Rounded product. A magnitude above 2^62 - 1 raises the overflow flag and
	// yields zero, as the hardware does.
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b, inout bit ovf);
		logic [127:0] p;
		p = {64'd0, mag64(a)} * {64'd0, mag64(b)} + (128'd1 << (IF_BITS - 1));
		p = p >> IF_BITS;
		if (p > MAG_LIM) begin
			ovf = 1;
			return 64'sd0;
		end
		return signed_of(p[63:0], a[63] ^ b[63]);
	endfunction

	// Rounded quotient by a positive integer.
	function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
			input logic [63:0] d);
		return signed_of((mag64(a) + d / 2) / d, a[63]);
	endfunction

	// Accumulator value to a Q16.16 result, saturating at the 32-bit range.
	function automatic logic [31:0] to_q16(input logic signed [63:0] v, inout logic [1:0] st);
		logic signed [63:0] q;
		q = signed_of((mag64(v) + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS, v[63]);
		if (q > 64'sd2147483647) begin
			st = STAT_SAT;
			return 32'h7FFF_FFFF;
		end
		if (q < -64'sd2147483648) begin
			st = STAT_SAT;
			return 32'h8000_0000;
		end
		return q[31:0];
	endfunction

	// Expected result of one function evaluation.
	function automatic res_t predict_result(input job_t j);
		res_t o;
		logic signed [63:0] v, x, num, den, k, r, r2, t, acc, a, d, d2;
		logic [127:0] wide, quo, rem;
		logic [63:0] div;
		logic [1:0] quad, st;
		bit ovf, odd;
		int n;
		v = 64'(j.arg);
		x = v <<< GUARD_BITS;
		st = STAT_OK;
		ovf = 0;
		n = 0;
		o.result = '0;
		case (j.mode)
			MODE_SIN, MODE_COS: begin
				// Nearest multiple of pi/2, floored division on exact values.
				num = 2 * x + HALF_PI;
				den = 2 * HALF_PI;
				k = num >= 0 ? num / den : -((-num + den - 1) / den);
				r = x - k * HALF_PI;
				quad = k[1:0] + j.mode;
				// Quadrants 0 and 2 use the sine series of the remainder.
				odd = !quad[0];
				r2 = fx_mul(r, r, ovf);
				t = odd ? r : ONE;
				acc = t;
				n = 1;
				while (n < SER_TERMS && t != 0) begin
					div = odd ? 64'(4 * n * n + 2 * n) : 64'(4 * n * n - 2 * n);
					t = -fx_div(fx_mul(t, r2, ovf), div);
					acc += t;
					n++;
				end
				if (quad[1])
					acc = -acc;
				o.result = to_q16(acc, st);
			end
			MODE_EXP: begin
				t = ONE;
				acc = ONE;
				n = 1;
				while (n < SER_TERMS && t != 0) begin
					t = fx_div(fx_mul(t, x, ovf), 64'(n));
					if (ovf)
						break;
					acc += t;
					if (acc > LIM || acc < -LIM) begin
						ovf = 1;
						break;
					end
					n++;
				end
				if (ovf) begin
					st = STAT_SAT;
					o.result = x > 0 ? 32'h7FFF_FFFF : 32'h0;
				end else begin
					o.result = to_q16(acc, st);
				end
			end
			default: begin
				if (v <= 0) begin
					st = STAT_DOMAIN;
				end else begin
					// d = (x - 1) / (x + 1), rounded to 32 fraction bits.
					a = v - (64'sd1 <<< FRAC_BITS);
					wide = {64'd0, mag64(a)} << IF_BITS;
					quo = wide / 128'(v + (64'sd1 <<< FRAC_BITS));
					rem = wide % 128'(v + (64'sd1 <<< FRAC_BITS));
					if (2 * rem >= 128'(v + (64'sd1 <<< FRAC_BITS)))
						quo++;
					d = signed_of(quo[63:0], a[63]);
					d2 = fx_mul(d, d, ovf);
					t = d;
					acc = d;
					n = 1;
					while (n < LOG_TERMS && t != 0) begin
						t = fx_mul(t, d2, ovf);
						t = fx_div(t * (2 * n - 1), 64'(2 * n + 1));
						acc += t;
						n++;
					end
					o.result = to_q16(2 * acc, st);
				end
			end
		endcase
		o.status = st;
		o.terms_used = n[10:0];
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// Directed stimulus. Rows with check set carry a result read off the
	// series by hand; the others are predicted.
	// ---------------------------------------------------------------------
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] arg;
		logic        check;
		logic [31:0] result;
		logic [1:0]  status;
		logic [10:0] terms;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	dir_row_t dir_rows [DIR_ROWS] = '{
		// Zero arguments: the series end on their first zero term.
		'{MODE_SIN, 32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK, 11'd1},
		'{MODE_COS, 32'h0000_0000, 1'b1, 32'h0001_0000, STAT_OK, 11'd2},
		'{MODE_EXP, 32'h0000_0000, 1'b1, 32'h0001_0000, STAT_OK, 11'd2},
		'{MODE_LN,  32'h0001_0000, 1'b1, 32'h0000_0000, STAT_OK, 11'd1},
		// Logarithm of nonpositive arguments is a domain error.
		'{MODE_LN,  32'h0000_0000, 1'b1, 32'h0000_0000, STAT_DOMAIN, 11'd0},
		'{MODE_LN,  32'h8000_0000, 1'b1, 32'h0000_0000, STAT_DOMAIN, 11'd0},
		'{MODE_LN,  32'hFFFF_0000, 1'b1, 32'h0000_0000, STAT_DOMAIN, 11'd0},
		// Exponential overflow at the extremes. For the most positive argument
		// the square still fits just below the limit and the cube overflows;
		// for the most negative one the square already overflows.
		'{MODE_EXP, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, STAT_SAT, 11'd3},
		'{MODE_EXP, 32'h8000_0000, 1'b1, 32'h0000_0000, STAT_SAT, 11'd2},
		// Argument extremes and all four quadrants of the reduction.
		'{MODE_SIN, 32'h7FFF_FFFF, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_SIN, 32'h8000_0000, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_COS, 32'h7FFF_FFFF, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_COS, 32'h8000_0000, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_SIN, 32'h0000_C90F, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_COS, 32'h0001_921F, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_SIN, 32'hFFFC_DBC1, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_COS, 32'h0004_B65F, 1'b0, 32'h0, STAT_OK, 11'd0},
		// Exponential in range, with a saturated result, and far negative.
		'{MODE_EXP, 32'h0001_0000, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_EXP, 32'hFFFF_0000, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_EXP, 32'h000B_0000, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_EXP, 32'hFFEC_0000, 1'b0, 32'h0, STAT_OK, 11'd0},
		// Logarithm at both ends of the positive range, which runs the longest series, and of 2.
		'{MODE_LN,  32'h7FFF_FFFF, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_LN,  32'h0000_0001, 1'b0, 32'h0, STAT_OK, 11'd0},
		'{MODE_LN,  32'h0002_0000, 1'b0, 32'h0, STAT_OK, 11'd0}
	};

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Random argument suited to the function, so that most items exercise the
	// interesting part of each series and only a few hit the long log series.
	function automatic job_t random_job();
		job_t j;
		int p;
		j.mode = 2'($urandom_range(0, 3));
		p = $urandom_range(0, 99);
		case (j.mode)
			MODE_SIN, MODE_COS:
				j.arg = p < 60 ? $urandom : $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
			MODE_EXP:
				j.arg = p < 15 ? $urandom : $signed($urandom_range(0, 32'h0018_0000)) - 32'sh000C_0000;
			default:
				if (p < 4)
					j.arg = $urandom;
				else if (p < 14)
					j.arg = -$signed($urandom_range(0, 32'h7FFF_FFFF));
				else
					j.arg = $urandom_range(32'h0000_5000, 32'h0003_0000);
		endcase
		return j;
	endfunction

	// Offers one item, waits for its transfer and records what it owes.
	// The valid stays high into the next item when there is no gap.
	task automatic send_job(input job_t j, input res_t want);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			job_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		job_valid <= 1'b1;
		job <= j;
		@(posedge clk);
		while (job_stall)
			@(posedge clk);
		pending_results.push_back(want);
	endtask

	// One line per mismatch, and a count.
	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
		errors++;
	endtask

	// Receiver: random stalls, plus one long hold-off on request so that the
	// block fills up and must stall the sender.
	initial begin
		int len;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			len = idle_len();
			if (len > 0) begin
				res_stall <= 1'b1;
				repeat (len) @(posedge clk);
			end
			res_stall <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Each result transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", res.result, 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (res.result !== want.result)
					report("result", res.result, want.result);
				if (res.status !== want.status)
					report("status", 32'(res.status), 32'(want.status));
				if (res.terms_used !== want.terms_used)
					report("terms_used", 32'(res.terms_used), 32'(want.terms_used));
			end
		end
	end

	// Reset, directed table, random items, then drain.
	initial begin
		job_t j;
		res_t want;
		int waited;
		arst_n = 1'b0;
		job_valid = 1'b0;
		job = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			j.mode = dir_rows[i].mode;
			j.arg = dir_rows[i].arg;
			if (dir_rows[i].check) begin
				want.result = dir_rows[i].result;
				want.status = dir_rows[i].status;
				want.terms_used = dir_rows[i].terms;
			end else begin
				want = predict_result(j);
			end
			send_job(j, want);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// Early on, the receiver holds off while items keep coming.
			if (i == 10)
				hold_req = 1;
			// Midway, the sender pauses until every owed result is back.
			if (i == 50) begin
				job_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			j = random_job();
			send_job(j, predict_result(j));
		end
		job_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// Give any stray result time to show up.
		waited = 0;
		while (waited < 300) begin
			@(posedge clk);
			waited++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
